// File: hw/rtl/bilinear_image_sampler_assert.svh
// Assertion macros for the bilinear image sampler.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BILINEAR_IMAGE_SAMPLER_ASSERT_SVH
`define BILINEAR_IMAGE_SAMPLER_ASSERT_SVH
`ifndef ASSERT_OFF
`define BIS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication check failed");
`define BIS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define BIS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BIS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hw/rtl/bis_pkg.sv
// Shared types and constants of the bilinear image sampler.
// No dependencies; used by the interfaces and by all modules but bis_ram.
package bis_pkg;

    localparam int CMP_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_THRESH = 2'd2;

    localparam logic [8:0]  RST_IMAGE_WIDTH  = 9'd256;
    localparam logic [8:0]  RST_IMAGE_HEIGHT = 9'd256;
    localparam logic [15:0] RST_BLACK_THRESH = 16'd1;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_EDGE   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LAST,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_action     action;
        logic [7:0]  pixel_row;
        logic [7:0]  pixel_col;
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
        logic [15:0] coord_y;
        logic [15:0] coord_x;
    } t_in_item;

    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic        is_edge;
        logic        out_of_range;
    } t_out_item;

    typedef struct packed {
        logic       load;
        logic       read;
        logic [1:0] step;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic outside;
        logic out_free;
    } t_status;

endpackage

// File: hw/rtl/bis_if.sv
// Handshake channel interfaces of the bilinear image sampler.
// Depends on bis_pkg for the payload types.
interface bis_in_if;
    import bis_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bis_out_if;
    import bis_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bis_cfg_if;
    import bis_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/bis_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module bis_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/bis_ctrl.sv
// Controller of the bilinear image sampler: sequences neighbor reads and result hand-off.
// Depends on bis_pkg.
module bis_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bis_pkg::t_action  i_action,
    input  bis_pkg::t_status  i_status,
    output bis_pkg::t_cmd     o_cmd
);
    import bis_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                n_step = 2'd0;
                if (i_in_valid && (i_action == ACT_SAMPLE || i_action == ACT_EDGE)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (i_status.outside) begin
                    n_state = S_EMIT;
                end else begin
                    n_step = r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        n_state = S_LAST;
                    end
                end
            end
            S_LAST: n_state = S_EMIT;
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        o_cmd.read = (r_state == S_READ) && !i_status.outside;
        o_cmd.step = r_step;
        o_cmd.emit = (r_state == S_EMIT) && i_status.out_free;
    end
endmodule

// File: hw/rtl/bis_dp.sv
// Datapath of the bilinear image sampler: config registers, pixel RAM, weights, accumulators.
// Depends on bis_pkg, bis_ram and the assertion macro header.
`include "bilinear_image_sampler_assert.svh"
module bis_dp #(
    parameter int MAX_WIDTH     = 256,
    parameter int MAX_HEIGHT    = 256,
    parameter int CHANNEL_BITS  = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bis_pkg::t_in_item                  i_in_data,
    input  logic                               i_cfg_valid,
    input  logic [bis_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bis_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    input  bis_pkg::t_cmd                      i_cmd,
    output bis_pkg::t_status                   o_status,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output bis_pkg::t_out_item                 o_out_data
);
    import bis_pkg::*;

    localparam int CB  = CHANNEL_BITS;
    localparam int FB  = FRACTION_BITS;
    localparam int IW  = 16 - FB;
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int CLW = $clog2(MAX_WIDTH);
    localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int WW  = 2 * FB + 1;
    localparam int SW  = CB + 2 * FB + 2;
    localparam int TW  = (CB > 16) ? CB : 16;
    localparam logic [FB:0]   ONE      = (FB + 1)'(1) << FB;
    localparam logic [SW-1:0] HALF     = SW'(1) << (2 * FB - 1);
    localparam logic [CB-1:0] CHAN_MAX = {CB{1'b1}};

    logic [8:0]  r_width, r_height;
    logic [15:0] r_thresh;
    logic [CMP_W-1:0] uw, uh;

    logic [IW-1:0] y0, x0;
    logic [FB-1:0] fy, fx;
    logic [IW:0]   y1, x1;
    logic          outside, wr_ok, ram_we;

    logic [RW-1:0]  r_y0, r_y1;
    logic [CLW-1:0] r_x0, r_x1;
    logic [FB-1:0]  r_fy, r_fx;
    logic           r_outside, r_edge_act;

    logic           ysel, xsel;
    logic [RW-1:0]  rd_row;
    logic [CLW-1:0] rd_col;
    logic [AW-1:0]  rd_addr, wr_addr, ram_addr;
    logic [FB:0]    wy, wx;
    logic [WW-1:0]  r_weight;
    logic           r_acc_en;

    logic [3*CB-1:0] ram_wdata, ram_rdata;
    logic [CB-1:0]   pix_r, pix_g, pix_b, pix_max;
    logic [SW-1:0]   r_acc_r, r_acc_g, r_acc_b;
    logic            r_black;

    logic      r_out_valid;
    t_out_item r_out, n_out;

    function automatic logic [15:0] round_chan(input logic [SW-1:0] acc);
        logic [SW-1:0] t;
        logic [CB-1:0] c;
        t = (acc + HALF) >> (2 * FB);
        c = (t > SW'(CHAN_MAX)) ? CHAN_MAX : t[CB-1:0];
        return 16'(c);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_IMAGE_WIDTH;
            r_height <= RST_IMAGE_HEIGHT;
            r_thresh <= RST_BLACK_THRESH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[8:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[8:0];
                CFG_BLACK_THRESH: r_thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        uw = (CMP_W'(r_width) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : CMP_W'(r_width);
        uh = (CMP_W'(r_height) > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT) : CMP_W'(r_height);
        y0 = i_in_data.coord_y[15:FB];
        x0 = i_in_data.coord_x[15:FB];
        fy = i_in_data.coord_y[FB-1:0];
        fx = i_in_data.coord_x[FB-1:0];
        y1 = (IW + 1)'(y0) + (IW + 1)'(fy != '0);
        x1 = (IW + 1)'(x0) + (IW + 1)'(fx != '0);
        outside = (CMP_W'(y1) >= uh) || (CMP_W'(x1) >= uw);
        wr_ok = (i_in_data.action == ACT_WRITE) && (CMP_W'(i_in_data.pixel_row) < uh)
                && (CMP_W'(i_in_data.pixel_col) < uw);
        ram_we  = i_cmd.load && wr_ok;
        wr_addr = AW'(RW'(i_in_data.pixel_row)) * AW'(MAX_WIDTH)
                  + AW'(CLW'(i_in_data.pixel_col));
        ram_wdata = {CB'(i_in_data.blue_in), CB'(i_in_data.green_in), CB'(i_in_data.red_in)};

        ysel    = i_cmd.step[0] ^ i_cmd.step[1];
        xsel    = i_cmd.step[1];
        rd_row  = ysel ? r_y1 : r_y0;
        rd_col  = xsel ? r_x1 : r_x0;
        rd_addr = AW'(rd_row) * AW'(MAX_WIDTH) + AW'(rd_col);
        ram_addr = i_cmd.load ? wr_addr : rd_addr;
        wy = ysel ? (FB + 1)'(r_fy) : ONE - (FB + 1)'(r_fy);
        wx = xsel ? (FB + 1)'(r_fx) : ONE - (FB + 1)'(r_fx);
    end

    bis_ram #(
        .WIDTH (3 * CB),
        .DEPTH (MAX_WIDTH * MAX_HEIGHT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_y0       <= RW'(y0);
            r_y1       <= RW'(y1);
            r_x0       <= CLW'(x0);
            r_x1       <= CLW'(x1);
            r_fy       <= fy;
            r_fx       <= fx;
            r_outside  <= outside;
            r_edge_act <= (i_in_data.action == ACT_EDGE);
        end
        if (i_cmd.read) begin
            r_weight <= WW'(wy) * WW'(wx);
        end
    end

    always_comb begin
        pix_r   = ram_rdata[CB-1:0];
        pix_g   = ram_rdata[2*CB-1:CB];
        pix_b   = ram_rdata[3*CB-1:2*CB];
        pix_max = pix_r;
        if (pix_g > pix_max) pix_max = pix_g;
        if (pix_b > pix_max) pix_max = pix_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= i_cmd.read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc_r <= '0;
            r_acc_g <= '0;
            r_acc_b <= '0;
            r_black <= 1'b0;
        end else if (r_acc_en) begin
            r_acc_r <= r_acc_r + SW'(pix_r) * SW'(r_weight);
            r_acc_g <= r_acc_g + SW'(pix_g) * SW'(r_weight);
            r_acc_b <= r_acc_b + SW'(pix_b) * SW'(r_weight);
            r_black <= r_black | (TW'(pix_max) < TW'(r_thresh));
        end
    end

    always_comb begin
        n_out = '0;
        if (r_edge_act) begin
            n_out.is_edge = r_outside | r_black;
        end else if (r_outside) begin
            n_out.out_of_range = 1'b1;
        end else begin
            n_out.red_out   = round_chan(r_acc_r);
            n_out.green_out = round_chan(r_acc_g);
            n_out.blue_out  = round_chan(r_acc_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_status.outside  = r_outside;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

    `BIS_ASSERT_IMP(a_emit_slot_free, i_clk, i_rst_n, i_cmd.emit, !r_out_valid || i_out_ready)
    `BIS_ASSERT_IMP(a_no_write_on_read, i_clk, i_rst_n, ram_we, !i_cmd.read)
    `BIS_ASSERT_IMP(a_valid_from_emit, i_clk, i_rst_n, $rose(r_out_valid), $past(i_cmd.emit))
    `BIS_ASSERT_NEXT(a_read_feeds_acc, i_clk, i_rst_n, i_cmd.read, r_acc_en)
endmodule

// File: hw/rtl/bilinear_image_sampler.sv
// Bilinear RGB sampler over a single-port pixel RAM loaded by write beats.
// Depends on bis_pkg, bis_if, bis_ctrl and bis_dp.
// A write beat is written into the pixel RAM as it is accepted. A sample or black-edge beat
// goes from acceptance to result in steps: capture of the position, four reads of the
// single-port pixel RAM (one per neighbor, each multiplied into the accumulators as its data
// returns), a step to finish the last accumulation, then the result is loaded into the output
// register once that register is free. A position out of range skips the reads. The next beat
// is accepted as soon as the result sits in the output register. The pixel RAM has no reset;
// configuration takes effect on the cycle after its write beat.
module bilinear_image_sampler #(
    parameter int MAX_WIDTH     = 256,
    parameter int MAX_HEIGHT    = 256,
    parameter int CHANNEL_BITS  = 16,
    parameter int FRACTION_BITS = 8
) (
    input logic       i_clk,
    input logic       i_rst_n,
    bis_in_if.sink    i_in,
    bis_out_if.source o_out,
    bis_cfg_if.sink   i_cfg
);
    import bis_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign i_cfg.ready = 1'b1;

    bis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_action   (i_in.payload.action),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bis_dp #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .CHANNEL_BITS  (CHANNEL_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in.payload),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.payload)
    );
endmodule

// File: bench/tb_bilinear_image_sampler.sv
// Self-checking bench for bilinear_image_sampler: directed, register-extreme, random and
// backpressure tests against a predictor of the pixel store and the bilinear blend.
// Depends on bis_pkg, bis_if and the sampler RTL.
module tb_bilinear_image_sampler;
    timeunit 1ns;
    timeprecision 1ps;
    import bis_pkg::*;

    localparam int  STORE_W     = 256;
    localparam int  SETTLE_CYC  = 12;
    localparam longint CYC_LIMIT = 600000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    bis_in_if  in_ch ();
    bis_out_if out_ch ();
    bis_cfg_if cfg_ch ();

    bilinear_image_sampler u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    logic [47:0] pix_mem [0:65535];
    bit          pix_known [0:65535];
    logic [8:0]  width_reg = RST_IMAGE_WIDTH;
    logic [8:0]  height_reg = RST_IMAGE_HEIGHT;
    logic [15:0] thresh_reg = RST_BLACK_THRESH;
    t_out_item   blend_q [$];
    int          errors = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_cycles = 0;
    longint      cycles = 0;

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
    end

    function automatic int unsigned usable(logic [8:0] r);
        return (r > 9'd256) ? 256 : int'(r);
    endfunction

    function automatic bit is_dark(int unsigned y, int unsigned x);
        logic [47:0] p;
        logic [15:0] m;
        p = pix_mem[y*STORE_W + x];
        m = p[47:32];
        if (p[31:16] > m) m = p[31:16];
        if (p[15:0] > m) m = p[15:0];
        return m < thresh_reg;
    endfunction

    task automatic model_beat(t_in_item it);
        int unsigned w, h, y0, x0, y1, x1, fy, fx, wt [4];
        int unsigned addr [4];
        longint unsigned s;
        bit outside;
        t_out_item r;
        w = usable(width_reg);
        h = usable(height_reg);
        r = '0;
        case (it.action)
            ACT_WRITE: begin
                if (it.pixel_row < h && it.pixel_col < w) begin
                    pix_mem[it.pixel_row*STORE_W + it.pixel_col] =
                        {it.red_in, it.green_in, it.blue_in};
                    pix_known[it.pixel_row*STORE_W + it.pixel_col] = 1'b1;
                end
            end
            ACT_SAMPLE, ACT_EDGE: begin
                fy = it.coord_y[7:0];
                fx = it.coord_x[7:0];
                y0 = it.coord_y[15:8];
                x0 = it.coord_x[15:8];
                y1 = y0 + (fy != 0);
                x1 = x0 + (fx != 0);
                outside = (y1 >= h) || (x1 >= w);
                if (it.action == ACT_EDGE) begin
                    r.is_edge = outside || is_dark(y0, x0) || is_dark(y1, x0) ||
                                is_dark(y1, x1) || is_dark(y0, x1);
                end else if (outside) begin
                    r.out_of_range = 1'b1;
                end else begin
                    wt[0] = (256 - fy) * (256 - fx);
                    wt[1] = fy * (256 - fx);
                    wt[2] = fy * fx;
                    wt[3] = (256 - fy) * fx;
                    addr[0] = y0*STORE_W + x0;
                    addr[1] = y1*STORE_W + x0;
                    addr[2] = y1*STORE_W + x1;
                    addr[3] = y0*STORE_W + x1;
                    for (int k = 0; k < 3; k++) begin
                        s = 0;
                        for (int n = 0; n < 4; n++)
                            s += longint'(pix_mem[addr[n]][47-16*k -: 16]) * wt[n];
                        s = (s + 32768) >> 16;
                        if (s > 65535) s = 65535;
                        if (k == 0) r.red_out = s[15:0];
                        else if (k == 1) r.green_out = s[15:0];
                        else r.blue_out = s[15:0];
                    end
                end
                blend_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic send_beat(t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.payload = it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        model_beat(it);
    endtask

    function automatic t_in_item noise_item();
        t_in_item it;
        it = $bits(t_in_item)'({$urandom, $urandom, $urandom, $urandom});
        return it;
    endfunction

    function automatic logic [15:0] rand_chan();
        case ($urandom_range(3))
            0: return 16'($urandom_range(3));
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_pixel(int unsigned row, int unsigned col);
        t_in_item it;
        it = noise_item();
        it.action    = ACT_WRITE;
        it.pixel_row = row[7:0];
        it.pixel_col = col[7:0];
        it.red_in    = rand_chan();
        it.green_in  = rand_chan();
        it.blue_in   = rand_chan();
        send_beat(it);
    endtask

    task automatic fill_if_unknown(int unsigned y, int unsigned x);
        if (!pix_known[y*STORE_W + x]) write_pixel(y, x);
    endtask

    task automatic query(t_action act, logic [15:0] cy, logic [15:0] cx);
        t_in_item it;
        int unsigned y0, x0, y1, x1;
        y0 = cy[15:8];
        x0 = cx[15:8];
        y1 = y0 + (cy[7:0] != 0);
        x1 = x0 + (cx[7:0] != 0);
        if (y1 < usable(height_reg) && x1 < usable(width_reg)) begin
            fill_if_unknown(y0, x0);
            fill_if_unknown(y1, x0);
            fill_if_unknown(y1, x1);
            fill_if_unknown(y0, x1);
        end
        it = noise_item();
        it.action  = act;
        it.coord_y = cy;
        it.coord_x = cx;
        send_beat(it);
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        wait (blend_q.size() == 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        settle();
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            CFG_IMAGE_WIDTH:  width_reg  = val[8:0];
            CFG_IMAGE_HEIGHT: height_reg = val[8:0];
            CFG_BLACK_THRESH: thresh_reg = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            out_ch.ready = 1'b0;
            hold_cycles--;
        end else begin
            out_ch.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (blend_q.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, out_ch.payload);
                errors++;
            end else begin
                want = blend_q.pop_front();
                if (want.red_out !== out_ch.payload.red_out) begin
                    $display("%0t: red expected %h actual %h", $time,
                             want.red_out, out_ch.payload.red_out);
                    errors++;
                end
                if (want.green_out !== out_ch.payload.green_out) begin
                    $display("%0t: green expected %h actual %h", $time,
                             want.green_out, out_ch.payload.green_out);
                    errors++;
                end
                if (want.blue_out !== out_ch.payload.blue_out) begin
                    $display("%0t: blue expected %h actual %h", $time,
                             want.blue_out, out_ch.payload.blue_out);
                    errors++;
                end
                if (want.is_edge !== out_ch.payload.is_edge) begin
                    $display("%0t: is_edge expected %b actual %b", $time,
                             want.is_edge, out_ch.payload.is_edge);
                    errors++;
                end
                if (want.out_of_range !== out_ch.payload.out_of_range) begin
                    $display("%0t: out_of_range expected %b actual %b", $time,
                             want.out_of_range, out_ch.payload.out_of_range);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_directed();
        t_in_item it;
        write_pixel(0, 0);
        write_pixel(0, 1);
        write_pixel(1, 0);
        write_pixel(1, 1);
        query(ACT_SAMPLE, 16'h0080, 16'h0080);
        query(ACT_SAMPLE, 16'h0000, 16'h0000);
        query(ACT_SAMPLE, 16'h00FF, 16'h0001);
        query(ACT_EDGE, 16'h0080, 16'h0080);
        write_pixel(255, 255);
        query(ACT_SAMPLE, 16'hFF00, 16'hFF00);
        query(ACT_EDGE, 16'hFF00, 16'hFF00);
        query(ACT_SAMPLE, 16'hFF80, 16'hFF00);
        query(ACT_SAMPLE, 16'hFFFF, 16'hFFFF);
        query(ACT_EDGE, 16'hFF00, 16'hFF01);
        it = noise_item();
        it.action = ACT_NONE;
        send_beat(it);
        it = noise_item();
        it.action = ACT_NONE;
        send_beat(it);
        write_pixel(2, 2);
        query(ACT_SAMPLE, 16'h0101, 16'h01FF);
        query(ACT_EDGE, 16'h0100, 16'h0000);
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_IMAGE_WIDTH, 16'd0);
        query(ACT_SAMPLE, 16'h0000, 16'h0000);
        query(ACT_EDGE, 16'h0000, 16'h0000);
        write_pixel(0, 0);
        write_reg(CFG_IMAGE_WIDTH, 16'h01FF);
        write_reg(CFG_IMAGE_HEIGHT, 16'd1);
        write_pixel(5, 5);
        query(ACT_SAMPLE, 16'h0000, 16'hFE80);
        query(ACT_SAMPLE, 16'h0080, 16'h0000);
        query(ACT_EDGE, 16'h0000, 16'h0300);
        write_reg(CFG_BLACK_THRESH, 16'd0);
        query(ACT_EDGE, 16'h0000, 16'h0000);
        write_reg(CFG_BLACK_THRESH, 16'hFFFF);
        query(ACT_EDGE, 16'h0000, 16'h0040);
        write_reg(CFG_IMAGE_HEIGHT, 16'd256);
        write_reg(CFG_IMAGE_WIDTH, 16'd1);
        query(ACT_SAMPLE, 16'h0440, 16'h0000);
        query(ACT_EDGE, 16'h0500, 16'h0000);
    endtask

    task automatic random_phase(int n, int idle, int stall);
        int unsigned h, w;
        t_in_item it;
        settle();
        idle_pct  = idle;
        stall_pct = stall;
        case ($urandom_range(3))
            0: begin
                write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(1, 256)));
                write_reg(CFG_IMAGE_HEIGHT, 16'($urandom_range(1, 4)));
            end
            1: begin
                write_reg(CFG_IMAGE_WIDTH, 16'd256);
                write_reg(CFG_IMAGE_HEIGHT, 16'd256);
            end
            default: begin
                write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(2, 12)));
                write_reg(CFG_IMAGE_HEIGHT, 16'($urandom_range(2, 12)));
            end
        endcase
        write_reg(CFG_BLACK_THRESH, ($urandom_range(1) == 0) ? 16'($urandom_range(0, 8))
                                                             : 16'($urandom));
        h = usable(height_reg);
        w = usable(width_reg);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(19))
                0, 1: write_pixel($urandom_range(255), $urandom_range(255));
                2: begin
                    it = noise_item();
                    it.action = ACT_NONE;
                    send_beat(it);
                end
                3: query(($urandom_range(1) == 0) ? ACT_SAMPLE : ACT_EDGE,
                         16'($urandom), 16'($urandom));
                default: begin
                    if (h > 12 || w > 12) begin
                        query(($urandom_range(2) == 0) ? ACT_EDGE : ACT_SAMPLE,
                              16'($urandom_range(0, ((h > 12) ? 12 : h) * 256 - 1)),
                              16'($urandom_range(0, ((w > 12) ? 12 : w) * 256 - 1)));
                    end else begin
                        query(($urandom_range(2) == 0) ? ACT_EDGE : ACT_SAMPLE,
                              16'($urandom_range(0, h * 256 - 1)),
                              16'($urandom_range(0, w * 256 - 1)));
                    end
                end
            endcase
        end
    endtask

    task automatic test_random();
        for (int r = 0; r < 2; r++) begin
            random_phase(100, 0, 0);
            random_phase(100, 76, 0);
            random_phase(100, 0, 76);
            random_phase(100, 13, 13);
        end
    endtask

    task automatic test_backpressure();
        settle();
        idle_pct  = 0;
        stall_pct = 0;
        write_reg(CFG_IMAGE_WIDTH, 16'd4);
        write_reg(CFG_IMAGE_HEIGHT, 16'd4);
        hold_cycles = 300;
        for (int i = 0; i < 30; i++)
            query(($urandom_range(1) == 0) ? ACT_EDGE : ACT_SAMPLE,
                  16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_config_extremes();
        test_random();
        test_backpressure();
        settle();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/bis_pkg.sv
hw/rtl/bis_if.sv
hw/rtl/bis_ram.sv
hw/rtl/bis_ctrl.sv
hw/rtl/bis_dp.sv
hw/rtl/bilinear_image_sampler.sv
bench/tb_bilinear_image_sampler.sv
